// ===== design/fall_detector_peak_rms_defines.svh =====
// Assertion macros shared by the design files.
`ifndef FALL_DETECTOR_PEAK_RMS_DEFINES_SVH
`define FALL_DETECTOR_PEAK_RMS_DEFINES_SVH

// An implication that must hold at every clock edge outside reset.
`define FDPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

// An implication whose consequent is checked in the next cycle.
`define FDPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== design/fdpr_pkg.sv =====
`default_nettype none
package fdpr_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] REG_RMS_WINDOW = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_PEAK_WINDOW = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_RATIO = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_DELTA = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_REFRACTORY = 3'd4;

    localparam logic [7:0] RMS_WINDOW_RST = 8'd100;
    localparam logic [3:0] PEAK_WINDOW_RST = 4'd5;
    localparam logic [7:0] RATIO_RST = 8'd32;
    localparam logic [15:0] DELTA_RST = 16'd2506;
    localparam logic [15:0] REFRACTORY_RST = 16'd2000;

    // Radicand width of the shared square root unit.
    localparam int unsigned SqrtInW = 34;
    localparam int unsigned SqrtOutW = 17;

    typedef struct packed {
        logic start;
        logic [SqrtInW-1:0] radicand;
    } sqrt_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [SqrtOutW-1:0] root;
    } sqrt_rsp_t;
endpackage
`default_nettype wire

// ===== design/fall_detector_peak_rms.sv =====
// A new sample is taken only when the previous one is through and no register write is pending;
// a waiting result does not hold off the next sample, though that sample's result waits for it.
// The processing time is set by the bit-serial square root (shared, used twice) and divider.
// Reset: async active low; registers return to defaults, windows and deque are empty.
// The magnitude ring memory needs no clearing pass; the fill count guards its reads.
`default_nettype none
`include "fall_detector_peak_rms_defines.svh"
module fall_detector_peak_rms
    import fdpr_pkg::*;
#(
    parameter int unsigned RMS_DEPTH = 128,
    parameter int unsigned PEAK_DEPTH = 8
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic [31:0] time_ms,
    output logic out_valid,
    input  wire logic out_stall,
    output logic [15:0] magnitude,
    output logic [15:0] peak,
    output logic [15:0] baseline,
    output logic fall
);
    localparam int unsigned AW = $clog2(RMS_DEPTH);
    localparam int unsigned FW = $clog2(RMS_DEPTH + 1);
    localparam int unsigned PW = $clog2(PEAK_DEPTH + 1);
    localparam int unsigned SumW = 32 + FW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ1 = 4'd1;
    localparam logic [3:0] S_SQ2 = 4'd2;
    localparam logic [3:0] S_MAG = 4'd3;
    localparam logic [3:0] S_MAGW = 4'd4;
    localparam logic [3:0] S_RING = 4'd5;
    localparam logic [3:0] S_OLDSQ = 4'd6;
    localparam logic [3:0] S_SUM = 4'd7;
    localparam logic [3:0] S_DIVW = 4'd8;
    localparam logic [3:0] S_BASEW = 4'd9;
    localparam logic [3:0] S_DEC = 4'd10;
    localparam logic [3:0] S_DQ = 4'd11;

    logic [3:0] state_reg, state_next;

    logic [7:0] rms_window_reg;
    logic [3:0] peak_window_reg;
    logic [7:0] ratio_reg;
    logic [15:0] delta_reg;
    logic [15:0] refractory_reg;

    logic [AW-1:0] pos_reg, pos_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [SumW-1:0] sum_reg, sum_next;
    logic [31:0] sample_reg, sample_next;
    logic [31:0] last_fall_reg, last_fall_next;
    logic [PW-1:0] dq_len_reg, dq_len_next;
    logic [15:0] dq_val_reg [PEAK_DEPTH];
    logic [31:0] dq_num_reg [PEAK_DEPTH];
    logic dq_we;

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic [31:0] now_reg;
    logic [31:0] sqa_reg, sqb_reg;
    logic [33:0] sq_reg, sq_next;
    logic [15:0] mag_reg, mag_next;
    logic [31:0] magsq_reg;
    logic [31:0] oldsq_reg;
    // Remembers whether the ring was full before this sample, so the evicted square is used.
    logic fill_was_full_reg;
    logic [15:0] base_reg, base_next;
    logic [15:0] peak_reg, peak_next;
    logic fall_reg, fall_next;
    logic out_valid_reg, out_valid_next;
    logic [15:0] o_mag_reg, o_peak_reg, o_base_reg;
    logic o_fall_reg;

    logic [FW-1:0] rw;
    logic [PW-1:0] pw;
    logic in_xfer, out_xfer, cfg_xfer, cfg_hit;

    sqrt_req_t sq_req;
    sqrt_rsp_t sq_rsp;
    logic div_start, div_done;
    logic [SumW-1:0] div_quo;
    logic ram_we;
    logic [15:0] ram_rdata;

    assign in_xfer = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign cfg_ready = (state_reg == S_IDLE);
    assign cfg_xfer = cfg_valid && cfg_ready;
    assign cfg_hit = cfg_xfer && (cfg_index <= REG_REFRACTORY);
    // A pending register write takes priority over a new sample.
    assign in_stall = (state_reg != S_IDLE) || cfg_valid;

    // Effective windows: zero acts as one, large values saturate at the depth.
    always_comb
    begin
        if (rms_window_reg == 8'd0)
            rw = FW'(1);
        else if (32'(rms_window_reg) > RMS_DEPTH)
            rw = FW'(RMS_DEPTH);
        else
            rw = FW'(rms_window_reg);
        if (peak_window_reg == 4'd0)
            pw = PW'(1);
        else if (32'(peak_window_reg) > PEAK_DEPTH)
            pw = PW'(PEAK_DEPTH);
        else
            pw = PW'(peak_window_reg);
    end

    fdpr_ram #(.WIDTH(16), .DEPTH(RMS_DEPTH)) u_ring (
        .clk(clk),
        .we(ram_we),
        .waddr(pos_reg),
        .wdata(mag_reg),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    fdpr_sqrt u_sqrt (
        .clk(clk),
        .rst_n(rst_n),
        .req(sq_req),
        .rsp(sq_rsp)
    );

    fdpr_div #(.NUM_W(SumW), .DEN_W(FW)) u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .num(sum_next),
        .den(fill_reg),
        .done(div_done),
        .quo(div_quo)
    );

    // Deque update helpers.
    logic [PW-1:0] keep_cnt;
    logic drop_head;
    logic [15:0] dqv_new [PEAK_DEPTH];
    logic [31:0] dqn_new [PEAK_DEPTH];
    logic [PW-1:0] len_tmp;

    always_comb
    begin
        len_tmp = (dq_len_reg > pw) ? pw : dq_len_reg;
        keep_cnt = '0;
        // Entries are non-increasing; keep the prefix strictly above the new value.
        for (int i = 0; i < PEAK_DEPTH; i++)
        begin
            if (PW'(i) < len_tmp && dq_val_reg[i] > mag_reg)
                keep_cnt = PW'(i + 1);
        end
        drop_head = (keep_cnt >= pw);
        for (int i = 0; i < PEAK_DEPTH; i++)
        begin
            dqv_new[i] = dq_val_reg[i];
            dqn_new[i] = dq_num_reg[i];
        end
        if (drop_head)
        begin
            for (int i = 0; i < PEAK_DEPTH - 1; i++)
            begin
                dqv_new[i] = dq_val_reg[i+1];
                dqn_new[i] = dq_num_reg[i+1];
            end
            keep_cnt = keep_cnt - 1'b1;
        end
        for (int i = 0; i < PEAK_DEPTH; i++)
        begin
            if (PW'(i) == keep_cnt)
            begin
                dqv_new[i] = mag_reg;
                dqn_new[i] = sample_reg;
            end
        end
        keep_cnt = keep_cnt + 1'b1;
        // Expire the head once it falls out of the window.
        if ((sample_reg - dqn_new[0]) >= 32'(pw))
        begin
            for (int i = 0; i < PEAK_DEPTH - 1; i++)
            begin
                dqv_new[i] = dqv_new[i+1];
                dqn_new[i] = dqn_new[i+1];
            end
            keep_cnt = keep_cnt - 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next = pos_reg;
        fill_next = fill_reg;
        sum_next = sum_reg;
        sample_next = sample_reg;
        last_fall_next = last_fall_reg;
        dq_len_next = dq_len_reg;
        dq_we = 1'b0;
        sq_next = sq_reg;
        mag_next = mag_reg;
        base_next = base_reg;
        peak_next = peak_reg;
        fall_next = fall_reg;
        out_valid_next = out_valid_reg;
        sq_req.start = 1'b0;
        sq_req.radicand = sq_reg;
        div_start = 1'b0;
        ram_we = 1'b0;
        if (out_xfer)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_hit)
                begin
                    pos_next = '0;
                    fill_next = '0;
                    sum_next = '0;
                    dq_len_next = '0;
                end
                else if (in_xfer)
                begin
                    sample_next = sample_reg + 32'd1;
                    if (32'(pos_reg) >= 32'(rw))
                        pos_next = '0;
                    state_next = S_SQ1;
                end
            end
            S_SQ1:
            begin
                sq_next = 34'(sqa_reg) + 34'(sqb_reg);
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                sq_next = sq_reg + 34'(sqa_reg);
                state_next = S_MAG;
            end
            S_MAG:
            begin
                sq_req.start = 1'b1;
                state_next = S_MAGW;
            end
            S_MAGW:
            begin
                if (sq_rsp.done)
                begin
                    mag_next = sq_rsp.root[15:0];
                    state_next = S_RING;
                end
            end
            S_RING:
            begin
                // Old entry is read this cycle and lands in ram_rdata next cycle.
                state_next = S_OLDSQ;
            end
            S_OLDSQ:
            begin
                ram_we = 1'b1;
                if (fill_reg >= rw)
                begin
                    fill_next = rw;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                end
                pos_next = (32'(pos_reg) + 32'd1 >= 32'(rw)) ? '0 : AW'(pos_reg + 1'b1);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next = sum_reg - ((fill_reg == rw && fill_was_full_reg) ?
                    SumW'(oldsq_reg) : '0) + SumW'(magsq_reg);
                // The divider takes the updated sum.
                div_start = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    sq_req.start = 1'b1;
                    sq_req.radicand = 34'(div_quo);
                    state_next = S_BASEW;
                end
            end
            S_BASEW:
            begin
                if (sq_rsp.done)
                begin
                    base_next = sq_rsp.root[15:0];
                    state_next = S_DQ;
                end
            end
            S_DQ:
            begin
                dq_we = 1'b1;
                dq_len_next = keep_cnt;
                peak_next = (keep_cnt != '0) ? dqv_new[0] : mag_reg;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (!out_valid_reg)
                begin
                    fall_next = 1'b0;
                    if ((now_reg - last_fall_reg) > 32'(refractory_reg) &&
                        (20'(peak_reg) * 20'd16 > 24'(base_reg) * 24'(ratio_reg)) &&
                        peak_reg > base_reg && (peak_reg - base_reg) > delta_reg)
                    begin
                        fall_next = 1'b1;
                        last_fall_next = now_reg;
                    end
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rms_window_reg <= RMS_WINDOW_RST;
            peak_window_reg <= PEAK_WINDOW_RST;
            ratio_reg <= RATIO_RST;
            delta_reg <= DELTA_RST;
            refractory_reg <= REFRACTORY_RST;
            pos_reg <= '0;
            fill_reg <= '0;
            sum_reg <= '0;
            sample_reg <= '0;
            last_fall_reg <= '0;
            dq_len_reg <= '0;
            out_valid_reg <= 1'b0;
            fill_was_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg <= pos_next;
            fill_reg <= fill_next;
            sum_reg <= sum_next;
            sample_reg <= sample_next;
            last_fall_reg <= last_fall_next;
            dq_len_reg <= dq_len_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == S_OLDSQ)
                fill_was_full_reg <= (fill_reg >= rw);
            if (cfg_xfer)
            begin
                unique case (cfg_index)
                    REG_RMS_WINDOW: rms_window_reg <= cfg_data[7:0];
                    REG_PEAK_WINDOW: peak_window_reg <= cfg_data[3:0];
                    REG_RATIO: ratio_reg <= cfg_data[7:0];
                    REG_DELTA: delta_reg <= cfg_data;
                    REG_REFRACTORY: refractory_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            now_reg <= time_ms;
        end
        // Squares of x and y are taken from the transfer itself, the z square follows.
        unique case (state_reg)
            S_SQ1:
            begin
                sqa_reg <= 32'(az_reg * az_reg);
            end
            S_IDLE:
            begin
                sqa_reg <= 32'(accel_x * accel_x);
                sqb_reg <= 32'(accel_y * accel_y);
            end
            default:
            begin
                sqa_reg <= sqa_reg;
            end
        endcase
        if (state_reg == S_RING)
            magsq_reg <= 32'(mag_reg) * 32'(mag_reg);
        if (state_reg == S_OLDSQ)
            oldsq_reg <= 32'(ram_rdata) * 32'(ram_rdata);
        sq_reg <= sq_next;
        mag_reg <= mag_next;
        base_reg <= base_next;
        peak_reg <= peak_next;
        fall_reg <= fall_next;
        if (dq_we)
        begin
            for (int i = 0; i < PEAK_DEPTH; i++)
            begin
                dq_val_reg[i] <= dqv_new[i];
                dq_num_reg[i] <= dqn_new[i];
            end
        end
        if (state_reg == S_DEC && !out_valid_reg)
        begin
            o_mag_reg <= mag_reg;
            o_peak_reg <= peak_reg;
            o_base_reg <= base_reg;
            o_fall_reg <= fall_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign magnitude = o_mag_reg;
    assign peak = o_peak_reg;
    assign baseline = o_base_reg;
    assign fall = o_fall_reg;

    `FDPR_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= FW'(RMS_DEPTH))
    `FDPR_ASSERT_IMP(a_dq_bound, clk, rst_n, 1'b1, dq_len_reg <= PW'(PEAK_DEPTH))
    `FDPR_ASSERT_NEXT(a_in_busy, clk, rst_n, in_xfer, state_reg == S_SQ1)
endmodule
`default_nettype wire

// ===== design/fdpr_ram.sv =====
`default_nettype none
module fdpr_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic clk,
    input  wire logic we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== design/fdpr_sqrt.sv =====
`default_nettype none
`include "fall_detector_peak_rms_defines.svh"
module fdpr_sqrt
    import fdpr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire sqrt_req_t req,
    output sqrt_rsp_t rsp
);
    // Restoring square root, one result bit per cycle.
    localparam int unsigned CntW = $clog2(SqrtOutW + 1);

    logic [SqrtInW-1:0] rem_reg, rem_next;
    logic [SqrtOutW-1:0] root_reg, root_next;
    logic [SqrtInW-1:0] rad_reg, rad_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [SqrtInW+1:0] trial;
    logic [SqrtInW+1:0] cand;

    always_comb
    begin
        rem_next = rem_reg;
        root_next = root_reg;
        rad_next = rad_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg, rad_reg[SqrtInW-1 -: 2]};
        cand = {{(SqrtInW+2-SqrtOutW-2){1'b0}}, root_reg, 2'b01};
        if (req.start)
        begin
            rem_next = '0;
            root_next = '0;
            rad_next = req.radicand;
            cnt_next = CntW'(SqrtOutW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SqrtInW-3:0], 2'b00};
            if (trial >= cand)
            begin
                rem_next = SqrtInW'(trial - cand);
                root_next = {root_reg[SqrtOutW-2:0], 1'b1};
            end
            else
            begin
                rem_next = SqrtInW'(trial);
                root_next = {root_reg[SqrtOutW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        root_reg <= root_next;
        rad_reg <= rad_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

    `FDPR_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg)
    `FDPR_ASSERT_NEXT(a_start_busy, clk, rst_n, req.start, busy_reg)
    `FDPR_ASSERT_IMP(a_cnt_busy, clk, rst_n, busy_reg, cnt_reg != '0)
endmodule
`default_nettype wire

// ===== design/fdpr_div.sv =====
`default_nettype none
`include "fall_detector_peak_rms_defines.svh"
module fdpr_div
    import fdpr_pkg::*;
#(
    parameter int unsigned NUM_W = 39,
    parameter int unsigned DEN_W = 11
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic done,
    output logic [NUM_W-1:0] quo
);
    // Restoring division, one quotient bit per cycle.
    localparam int unsigned CntW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0] r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [DEN_W+1:0] sh;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh = {r_reg, q_reg[NUM_W-1]};
        if (start)
        begin
            q_next = num;
            r_next = '0;
            d_next = den;
            cnt_next = CntW'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {2'b00, d_reg})
            begin
                r_next = (DEN_W+1)'(sh - {2'b00, d_reg});
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = (DEN_W+1)'(sh);
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo = q_reg;

    `FDPR_ASSERT_IMP(a_div_done, clk, rst_n, done_reg, !busy_reg)
    `FDPR_ASSERT_NEXT(a_div_start, clk, rst_n, start, busy_reg)
    `FDPR_ASSERT_IMP(a_div_cnt, clk, rst_n, busy_reg, cnt_reg != '0)
endmodule
`default_nettype wire

// ===== verif/fall_detector_peak_rms_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module fall_detector_peak_rms_tb;
    import fdpr_pkg::*;

    localparam int unsigned RING_DEPTH = 128;
    localparam int unsigned MAX_DEQUE = 8;
    localparam int unsigned SETTLE_CYCLES = 120;
    localparam longint unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [31:0] t;
    } sample_t;

    typedef struct {
        logic [15:0] magnitude;
        logic [15:0] peak;
        logic [15:0] baseline;
        logic fall;
    } detection_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0] time_ms;
    logic out_valid;
    logic out_stall;
    logic [15:0] magnitude;
    logic [15:0] peak;
    logic [15:0] baseline;
    logic fall;

    fall_detector_peak_rms dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .accel_x(accel_x),
        .accel_y(accel_y),
        .accel_z(accel_z),
        .time_ms(time_ms),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .magnitude(magnitude),
        .peak(peak),
        .baseline(baseline),
        .fall(fall)
    );

    sample_t pending_samples[$];
    detection_t expected_detections[$];
    int errors = 0;
    bit steady = 0;
    longint unsigned cycles = 0;
    logic [31:0] now_ms;

    // Shadow copy of the detector state.
    logic [7:0] m_rms_window;
    logic [3:0] m_peak_window;
    logic [7:0] m_ratio;
    logic [15:0] m_delta;
    logic [15:0] m_refractory;
    logic [15:0] m_ring[RING_DEPTH];
    int unsigned m_ring_pos;
    int unsigned m_ring_fill;
    longint unsigned m_sum_sq;
    logic [15:0] m_dq_val[MAX_DEQUE];
    logic [31:0] m_dq_num[MAX_DEQUE];
    int unsigned m_dq_len;
    logic [31:0] m_sample_num;
    logic [31:0] m_last_fall;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int unsigned clamp_win(int unsigned v, int unsigned depth);
        if (v == 0)
            return 1;
        return (v > depth) ? depth : v;
    endfunction

    function automatic void clear_windows();
        m_ring_pos = 0;
        m_ring_fill = 0;
        m_sum_sq = 0;
        m_dq_len = 0;
    endfunction

    function automatic void apply_register(logic [CfgIdxW-1:0] idx, logic [15:0] data);
        case (idx)
            REG_RMS_WINDOW: m_rms_window = data[7:0];
            REG_PEAK_WINDOW: m_peak_window = data[3:0];
            REG_RATIO: m_ratio = data[7:0];
            REG_DELTA: m_delta = data;
            REG_REFRACTORY: m_refractory = data;
            default: return;
        endcase
        clear_windows();
    endfunction

    function automatic void drop_oldest();
        for (int i = 0; i + 1 < m_dq_len; i++)
        begin
            m_dq_val[i] = m_dq_val[i + 1];
            m_dq_num[i] = m_dq_num[i + 1];
        end
        m_dq_len--;
    endfunction

    function automatic detection_t detect_fall(sample_t s);
        detection_t d;
        longint signed x, y, z;
        int unsigned rw, pw;
        longint unsigned mag, base, pk;
        x = s.x;
        y = s.y;
        z = s.z;
        rw = clamp_win(m_rms_window, RING_DEPTH);
        pw = clamp_win(m_peak_window, MAX_DEQUE);
        mag = isqrt(x * x + y * y + z * z) & 64'hFFFF;
        m_sample_num = m_sample_num + 1;

        if (m_ring_pos >= rw)
            m_ring_pos = 0;
        if (m_ring_fill >= rw)
        begin
            m_sum_sq -= longint'(m_ring[m_ring_pos]) * m_ring[m_ring_pos];
            m_ring_fill = rw;
        end
        else
            m_ring_fill++;
        m_ring[m_ring_pos] = mag[15:0];
        m_sum_sq += mag * mag;
        m_ring_pos = (m_ring_pos + 1 >= rw) ? 0 : m_ring_pos + 1;
        base = isqrt(m_sum_sq / m_ring_fill) & 64'hFFFF;

        if (m_dq_len > pw)
            m_dq_len = pw;
        while (m_dq_len > 0 && m_dq_val[m_dq_len - 1] <= mag)
            m_dq_len--;
        // A full deque gives up its oldest entry so the newest is always kept.
        if (m_dq_len >= pw)
            drop_oldest();
        m_dq_val[m_dq_len] = mag[15:0];
        m_dq_num[m_dq_len] = m_sample_num;
        m_dq_len++;
        while (m_dq_len > 0 && 32'(m_sample_num - m_dq_num[0]) >= pw)
            drop_oldest();
        pk = (m_dq_len > 0) ? m_dq_val[0] : mag;

        d.fall = 1'b0;
        if (32'(s.t - m_last_fall) > m_refractory)
        begin
            if (pk * 16 > base * m_ratio && pk > base && pk - base > m_delta)
            begin
                d.fall = 1'b1;
                m_last_fall = s.t;
            end
        end
        d.magnitude = mag[15:0];
        d.peak = pk[15:0];
        d.baseline = base[15:0];
        return d;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Sample driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            sample_t s;
            if (in_valid)
            begin
                s.x = accel_x;
                s.y = accel_y;
                s.z = accel_z;
                s.t = time_ms;
                expected_detections.push_back(detect_fall(s));
            end
            if (pending_samples.size() > 0 && (steady || $urandom_range(0, 99) >= 15))
            begin
                s = pending_samples.pop_front();
                accel_x <= s.x;
                accel_y <= s.y;
                accel_z <= s.z;
                time_ms <= s.t;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result monitor.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                detection_t e;
                if (expected_detections.size() == 0)
                begin
                    $display("%0t: unexpected result mag=%0d peak=%0d base=%0d fall=%0d",
                             $time, magnitude, peak, baseline, fall);
                    errors++;
                end
                else
                begin
                    e = expected_detections.pop_front();
                    if (magnitude !== e.magnitude)
                    begin
                        $display("%0t: magnitude expected %0d actual %0d",
                                 $time, e.magnitude, magnitude);
                        errors++;
                    end
                    if (peak !== e.peak)
                    begin
                        $display("%0t: peak expected %0d actual %0d", $time, e.peak, peak);
                        errors++;
                    end
                    if (baseline !== e.baseline)
                    begin
                        $display("%0t: baseline expected %0d actual %0d",
                                 $time, e.baseline, baseline);
                        errors++;
                    end
                    if (fall !== e.fall)
                    begin
                        $display("%0t: fall expected %0d actual %0d", $time, e.fall, fall);
                        errors++;
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(0, 99) < 15);
        end
    end

    task automatic write_register(logic [CfgIdxW-1:0] idx, logic [15:0] data);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_register(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_detections.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void queue_sample(int x, int y, int z);
        sample_t s;
        s.x = 16'(x);
        s.y = 16'(y);
        s.z = 16'(z);
        s.t = now_ms;
        pending_samples.push_back(s);
    endfunction

    // Mostly a resting sensor near 1 g with short impacts, some fully random samples.
    function automatic void queue_random(int count);
        sample_t s;
        int kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 19))
                0: now_ms = now_ms + $urandom_range(1000, 70000);
                1: now_ms = now_ms + $urandom();
                default: now_ms = now_ms + $urandom_range(1, 60);
            endcase
            if (kind < 70)
                queue_sample($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                             8192 + $urandom_range(0, 800) - 400);
            else if (kind < 85)
                queue_sample($urandom_range(0, 40000) - 20000, $urandom_range(0, 40000) - 20000,
                             ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(16000, 32767));
            else
            begin
                s.x = 16'($urandom());
                s.y = 16'($urandom());
                s.z = 16'($urandom());
                queue_sample(s.x, s.y, s.z);
            end
        end
    endfunction

    initial
    begin
        int rms_set[10] = '{0, 1, 128, 255, 2, 17, 100, 60, 127, 3};
        int peak_set[10] = '{1, 8, 15, 0, 2, 5, 3, 7, 9, 4};
        int ratio_set[10] = '{0, 255, 32, 16, 48, 0, 200, 24, 255, 32};
        int delta_set[10] = '{0, 65535, 2506, 500, 1000, 0, 3000, 65534, 100, 4000};
        int refr_set[10] = '{0, 65535, 2000, 100, 0, 500, 50, 1, 1000, 300};

        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        accel_x = '0;
        accel_y = '0;
        accel_z = '0;
        time_ms = '0;
        m_rms_window = RMS_WINDOW_RST;
        m_peak_window = PEAK_WINDOW_RST;
        m_ratio = RATIO_RST;
        m_delta = DELTA_RST;
        m_refractory = REFRACTORY_RST;
        clear_windows();
        m_sample_num = 0;
        m_last_fall = 0;
        now_ms = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: axis extremes, a fall at reset settings and timestamp wrap.
        queue_sample(0, 0, 0);
        queue_sample(-32768, -32768, -32768);
        queue_sample(32767, 32767, 32767);
        queue_sample(-32768, 32767, 0);
        queue_sample(0, 0, 8192);
        for (int i = 0; i < 6; i++)
            queue_sample(0, 0, 8192);
        now_ms = 3000;
        queue_sample(30000, -30000, 30000);
        queue_sample(0, 0, 8192);
        now_ms = 3500;
        queue_sample(32767, 32767, -32768);
        now_ms = 32'hFFFF_FF00;
        queue_sample(0, 0, 8192);
        queue_sample(-32768, -32768, 32767);
        now_ms = 32'h0000_0010;
        queue_sample(1, -1, 8192);
        queue_sample(32767, 0, 0);
        queue_random(170);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            write_register(REG_RMS_WINDOW, 16'(rms_set[p]) | (16'($urandom()) << 8));
            write_register(REG_PEAK_WINDOW, 16'(peak_set[p]) | (16'($urandom()) << 4));
            write_register(REG_RATIO, 16'(ratio_set[p]) | (16'($urandom()) << 8));
            write_register(REG_DELTA, 16'(delta_set[p]));
            write_register(REG_REFRACTORY, 16'(refr_set[p]));
            // Indexes past the register list must be ignored.
            write_register(CfgIdxW'(5 + (p % 3)), 16'($urandom()));
            steady = (p == 4);
            queue_random(p == 2 ? 300 : 150);
            wait_idle();
            steady = 0;
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
